/* src/cqmr_pkg.sv */
// ----------------------------------------------------------------------------
// cqmr_pkg: shared types and codes
// Request kinds, result status codes, sequencer states and the control
// word that the sequencer sends to every queue cell.
// ----------------------------------------------------------------------------
package cqmr_pkg;

   localparam int ValueWidth = 32;

   typedef enum logic [1:0] {
      KIND_PUSH       = 2'd0,
      KIND_POP        = 2'd1,
      KIND_REPORT_MAX = 2'd2,
      KIND_REMOVE_MAX = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctl_type;

endpackage

/* src/cqmr_cell.sv */
// ----------------------------------------------------------------------------
// cqmr_cell: one queue entry
// Holds the entry at a fixed offset from the front, loads a pushed value,
// takes its right neighbor's entry on a shift, and carries the running
// maximum one cell to the right in every cycle.
// ----------------------------------------------------------------------------
module cqmr_cell
   import cqmr_pkg::*;
#(
   parameter int Idx  = 0,
   parameter int IdxW = 3,
   parameter int CntW = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cell_ctl_type                 ctl,
   input  logic [CntW-1:0]              count,
   input  logic [IdxW-1:0]              shift_from,
   input  logic signed [ValueWidth-1:0] push_value,
   input  logic signed [ValueWidth-1:0] right_data,
   input  logic                         left_best_valid,
   input  logic signed [ValueWidth-1:0] left_best_value,
   input  logic [IdxW-1:0]              left_best_idx,
   output logic signed [ValueWidth-1:0] data,
   output logic                         best_valid,
   output logic signed [ValueWidth-1:0] best_value,
   output logic [IdxW-1:0]              best_idx
);

   logic signed [ValueWidth-1:0] data_ff, data_in;
   logic                         best_valid_ff, best_valid_in;
   logic signed [ValueWidth-1:0] best_value_ff, best_value_in;
   logic [IdxW-1:0]              best_idx_ff, best_idx_in;
   logic                         own_valid;

   assign own_valid = CntW'(Idx) < count;

   always_comb begin
      data_in = data_ff;
      if (ctl.load && count == CntW'(Idx)) begin
         data_in = push_value;
      end else if (ctl.shift && IdxW'(Idx) >= shift_from) begin
         data_in = right_data;
      end
   end

   // The left neighbor keeps the lead on ties, so the entry nearest the front wins.
   always_comb begin
      best_valid_in = 1'b0;
      best_value_in = left_best_value;
      best_idx_in   = left_best_idx;
      if (left_best_valid && !(own_valid && data_ff > left_best_value)) begin
         best_valid_in = 1'b1;
      end else if (own_valid) begin
         best_valid_in = 1'b1;
         best_value_in = data_ff;
         best_idx_in   = IdxW'(Idx);
      end
   end

   always_ff @(posedge clock) begin
      data_ff       <= data_in;
      best_value_ff <= best_value_in;
      best_idx_ff   <= best_idx_in;
      if (reset) begin
         best_valid_ff <= 1'b0;
      end else begin
         best_valid_ff <= best_valid_in;
      end
   end

   assign data       = data_ff;
   assign best_valid = best_valid_ff;
   assign best_value = best_value_ff;
   assign best_idx   = best_idx_ff;

endmodule

/* src/circular_queue_with_max_removal.sv */
// ----------------------------------------------------------------------------
// circular_queue_with_max_removal: bounded queue with maximum removal
// Entries sit in a row of cells in order from the front. A push loads the
// cell past the last entry, a pop or a removal shifts the cells behind the
// removed entry one place forward, and a running maximum walks the row.
//
//   Channel  Direction  tuser          tdata
//   req      in         kind           value
//   rsp      out        status         result_value, position, occupancy
//
// A push, a pop and any request that is rejected writes its result into the output register as it is taken.
// Reporting or removing the maximum first scans the cell row: the running
// maximum moves through the cell row one cell per cycle, and no request is taken until the scan ends.
// Reset empties the queue at once; entries are not cleared.
// In the idle state a new request is taken while a result waits, as long as that result
// leaves in the same cycle or the output register is empty.
// ----------------------------------------------------------------------------
module circular_queue_with_max_removal
   import cqmr_pkg::*;
#(
   parameter int DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [1:0]  req_tuser,   // [1:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] result_value, [34:32] position,
                                    // [38:35] occupancy, [39] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   localparam int IdxW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);
   localparam int PosW = (IdxW > 3) ? IdxW : 3;
   localparam int OccW = (CntW > 4) ? CntW : 4;

   state_type state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] scan_ff, scan_in;
   kind_type        kind_ff, kind_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   status_type                   rsp_status_ff, rsp_status_in;
   logic signed [ValueWidth-1:0] rsp_value_ff, rsp_value_in;
   logic [2:0]                   rsp_pos_ff, rsp_pos_in;
   logic [3:0]                   rsp_occ_ff, rsp_occ_in;

   cell_ctl_type    ctl;
   logic [IdxW-1:0] shift_from;
   logic            rsp_load;
   logic            accept;
   logic            scan_last;
   logic            empty;
   logic            full;
   kind_type        req_kind;
   logic [PosW-1:0] pos_wide;
   logic [OccW-1:0] occ_wide;

   logic signed [ValueWidth-1:0] cell_data [DEPTH];
   logic                         cell_best_valid [DEPTH];
   logic signed [ValueWidth-1:0] cell_best_value [DEPTH];
   logic [IdxW-1:0]              cell_best_idx [DEPTH];

   genvar k;
   generate
      for (k = 0; k < DEPTH; k++) begin : g_cell
         logic signed [ValueWidth-1:0] right_data;
         logic                         left_valid;
         logic signed [ValueWidth-1:0] left_value;
         logic [IdxW-1:0]              left_idx;
         if (k == DEPTH - 1) begin : g_last
            assign right_data = '0;
         end else begin : g_mid
            assign right_data = cell_data[k+1];
         end
         if (k == 0) begin : g_first
            assign left_valid = 1'b0;
            assign left_value = '0;
            assign left_idx   = '0;
         end else begin : g_rest
            assign left_valid = cell_best_valid[k-1];
            assign left_value = cell_best_value[k-1];
            assign left_idx   = cell_best_idx[k-1];
         end
         cqmr_cell #(
            .Idx  (k),
            .IdxW (IdxW),
            .CntW (CntW)
         ) u_cell (
            .clock           (clock),
            .reset           (reset),
            .ctl             (ctl),
            .count           (count_ff),
            .shift_from      (shift_from),
            .push_value      (req_tdata),
            .right_data      (right_data),
            .left_best_valid (left_valid),
            .left_best_value (left_value),
            .left_best_idx   (left_idx),
            .data            (cell_data[k]),
            .best_valid      (cell_best_valid[k]),
            .best_value      (cell_best_value[k]),
            .best_idx        (cell_best_idx[k])
         );
      end
   endgenerate

   assign req_kind  = kind_type'(req_tuser);
   assign accept    = req_tvalid && req_tready;
   assign empty     = count_ff == '0;
   assign full      = count_ff == CntW'(DEPTH);
   assign scan_last = scan_ff == CntW'(DEPTH - 1);
   assign pos_wide  = PosW'(cell_best_idx[DEPTH-1]);
   assign occ_wide  = OccW'(count_in);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !empty &&
                (req_kind == KIND_REPORT_MAX || req_kind == KIND_REMOVE_MAX)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready    = 1'b0;
      ctl           = '0;
      shift_from    = '0;
      count_in      = count_ff;
      scan_in       = '0;
      kind_in       = kind_ff;
      rsp_load      = 1'b0;
      rsp_status_in = STATUS_DONE;
      rsp_value_in  = '0;
      rsp_pos_in    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = !rsp_valid_ff || rsp_tready;
            if (accept) begin
               kind_in = req_kind;
               unique case (req_kind)
                  KIND_PUSH: begin
                     rsp_load = 1'b1;
                     if (full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        ctl.load = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  KIND_POP: begin
                     rsp_load = 1'b1;
                     if (empty) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        ctl.shift    = 1'b1;
                        rsp_value_in = cell_data[0];
                        count_in     = count_ff - 1'b1;
                     end
                  end
                  KIND_REPORT_MAX, KIND_REMOVE_MAX: begin
                     if (empty) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            scan_in = scan_ff + 1'b1;
            if (scan_last) begin
               rsp_load     = 1'b1;
               rsp_value_in = cell_best_value[DEPTH-1];
               rsp_pos_in   = pos_wide[2:0];
               if (kind_ff == KIND_REMOVE_MAX) begin
                  ctl.shift  = 1'b1;
                  shift_from = cell_best_idx[DEPTH-1];
                  count_in   = count_ff - 1'b1;
               end
            end
         end
         default: ;
      endcase
      rsp_occ_in   = occ_wide[3:0];
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_pos_ff    <= rsp_pos_in;
         rsp_occ_ff    <= rsp_occ_in;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {1'b0, rsp_occ_ff, rsp_pos_ff, rsp_value_ff};

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(DEPTH))
      else $error("Entry count exceeds the queue depth.");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("A result was written over one not yet transferred.");

   a_busy_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> !req_tready)
      else $error("A request was offered a transfer during a maximum scan.");

   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && scan_last && kind_ff == KIND_REMOVE_MAX)
      |=> count_ff == $past(count_ff) - 1'b1)
      else $error("Removing the maximum did not drop one entry.");
`endif

endmodule

/* tb/cqmr_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cqmr_checker: result checker for the circular queue with maximum removal
// Watches the request and result channels. Every accepted request is applied
// to a private copy of the queue, which yields the result it must produce.
// Every accepted result is compared field by field with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
module cqmr_checker
   import cqmr_pkg::*;
#(
   parameter int DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [1:0]  req_tuser,   // [1:0] kind
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // [31:0] result_value, [34:32] position,
                                    // [38:35] occupancy, [39] zero
   input  logic [1:0]  rsp_tuser,   // [1:0] status
   output int          mismatch_count,
   output int          results_pending
);

   typedef struct {
      status_type         status;
      logic signed [31:0] value;
      logic [2:0]         position;
      logic [3:0]         occupancy;
   } queue_result_type;

   logic signed [31:0] held_values[$];
   queue_result_type   predicted_results[$];
   int                 result_index = 0;

   task automatic report_mismatch(string what);
      $display("%0t ns: result %0d: %s", $time, result_index, what);
      mismatch_count++;
   endtask

   function automatic queue_result_type apply_request(kind_type kind,
                                                      logic signed [31:0] value);
      queue_result_type outcome;
      int               best;
      outcome.status   = STATUS_DONE;
      outcome.value    = '0;
      outcome.position = '0;
      if (kind == KIND_PUSH) begin
         if (held_values.size() >= DEPTH) begin
            outcome.status = STATUS_FULL;
         end else begin
            held_values.push_back(value);
         end
      end else if (held_values.size() == 0) begin
         outcome.status = STATUS_EMPTY;
      end else if (kind == KIND_POP) begin
         outcome.value = held_values.pop_front();
      end else begin
         // The first of several equal maxima, counted from the front, wins.
         best = 0;
         for (int k = 1; k < held_values.size(); k++) begin
            if (held_values[k] > held_values[best]) begin
               best = k;
            end
         end
         outcome.value    = held_values[best];
         outcome.position = 3'(best);
         if (kind == KIND_REMOVE_MAX) begin
            held_values.delete(best);
         end
      end
      outcome.occupancy = 4'(held_values.size());
      return outcome;
   endfunction

   always @(posedge clock) begin
      queue_result_type wanted;
      if (reset) begin
         held_values.delete();
         predicted_results.delete();
      end else begin
         // A result leaving now belongs to an earlier request, so it is
         // checked before a request taken on the same edge is applied.
         if (rsp_tvalid && rsp_tready) begin
            result_index++;
            if (predicted_results.size() == 0) begin
               report_mismatch("result transfer with no request waiting");
            end else begin
               wanted = predicted_results.pop_front();
               if (rsp_tuser != wanted.status) begin
                  report_mismatch($sformatf("status expected %0d got %0d",
                                            wanted.status, rsp_tuser));
               end
               if (rsp_tdata[31:0] != wanted.value) begin
                  report_mismatch($sformatf("value expected %0d got %0d",
                                            wanted.value,
                                            $signed(rsp_tdata[31:0])));
               end
               if (rsp_tdata[34:32] != wanted.position) begin
                  report_mismatch($sformatf("position expected %0d got %0d",
                                            wanted.position, rsp_tdata[34:32]));
               end
               if (rsp_tdata[38:35] != wanted.occupancy) begin
                  report_mismatch($sformatf("occupancy expected %0d got %0d",
                                            wanted.occupancy, rsp_tdata[38:35]));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predicted_results.push_back(apply_request(kind_type'(req_tuser),
                                                      req_tdata));
         end
      end
      results_pending <= predicted_results.size();
   end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the circular queue with maximum removal
// Drives a directed sequence through empty, full, tie, wrap and removal
// cases, then random request mixes that swing the queue between nearly empty
// and full. Both channels idle at random; the receiver also blocks for long
// stretches so that the queue backs up. The checker predicts every result.
// ----------------------------------------------------------------------------
module tb_top
   import cqmr_pkg::*;
();

   localparam int QueueDepth    = 8;
   localparam int RandomCount   = 750;
   localparam int IdleLimit     = 2000;
   localparam int SettleCycles  = 20;
   localparam int LongHoldCycles = 150;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = KIND_PUSH;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   int mismatch_count;
   int results_pending;
   int idle_cycles = 0;
   bit sender_no_gaps = 1'b0;
   bit receiver_no_stalls = 1'b0;

   always #6 clock = ~clock;

   circular_queue_with_max_removal #(
      .DEPTH(QueueDepth)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   cqmr_checker #(
      .DEPTH(QueueDepth)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   task automatic send_request(kind_type kind, logic [31:0] value);
      int gap;
      gap = sender_no_gaps ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_until_drained();
      do @(posedge clock); while (results_pending != 0);
   endtask

   function automatic logic [31:0] pick_value();
      logic [31:0] extremes[4];
      extremes = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0};
      case ($urandom_range(0, 7))
         0: begin
            return extremes[$urandom_range(0, 3)];
         end
         1, 2: begin
            // A narrow range makes equal maxima common.
            return 32'($signed($urandom_range(0, 6)) - 3);
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   initial begin
      int push_percent;
      kind_type kind;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_request(KIND_POP, $urandom);
      send_request(KIND_REPORT_MAX, $urandom);
      send_request(KIND_REMOVE_MAX, $urandom);
      send_request(KIND_PUSH, 32'h8000_0000);
      send_request(KIND_PUSH, 32'h7FFF_FFFF);
      send_request(KIND_PUSH, 32'hFFFF_FFFF);
      send_request(KIND_PUSH, 32'h0000_0000);
      send_request(KIND_PUSH, 32'h7FFF_FFFF);
      send_request(KIND_PUSH, 32'd5);
      send_request(KIND_PUSH, 32'h8000_0000);
      send_request(KIND_PUSH, 32'hFFFF_FFFF);
      send_request(KIND_PUSH, 32'd7);
      send_request(KIND_REPORT_MAX, $urandom);
      send_request(KIND_REMOVE_MAX, $urandom);
      send_request(KIND_POP, $urandom);
      send_request(KIND_REPORT_MAX, $urandom);
      send_request(KIND_PUSH, 32'd123);
      send_request(KIND_PUSH, 32'd124);
      send_request(KIND_PUSH, 32'd125);
      send_request(KIND_REMOVE_MAX, $urandom);
      send_request(KIND_REMOVE_MAX, $urandom);
      send_request(KIND_REMOVE_MAX, $urandom);
      send_request(KIND_POP, $urandom);
      send_request(KIND_POP, $urandom);
      send_request(KIND_REMOVE_MAX, $urandom);
      req_tvalid <= 1'b0;
      wait_until_drained();

      push_percent = 50;
      for (int n = 0; n < RandomCount; n++) begin
         if (n % 50 == 0) begin
            case ($urandom_range(0, 2))
               0: push_percent = 75;
               1: push_percent = 30;
               default: push_percent = 50;
            endcase
            sender_no_gaps = ($urandom_range(0, 2) == 0);
         end
         if (n == RandomCount / 2) begin
            req_tvalid <= 1'b0;
            wait_until_drained();
         end
         if ($urandom_range(0, 99) < push_percent) begin
            kind = KIND_PUSH;
         end else begin
            kind = kind_type'($urandom_range(1, 3));
         end
         send_request(kind, pick_value());
      end
      req_tvalid <= 1'b0;

      wait_until_drained();
      repeat (SettleCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      int stall;
      int taken;
      taken = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (taken == 100 || taken == 450) begin
            stall = LongHoldCycles;
         end else if (receiver_no_stalls) begin
            stall = 0;
         end else begin
            stall = $urandom_range(0, 10);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
         if (taken % 60 == 0) begin
            receiver_no_stalls = ($urandom_range(0, 2) == 0);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

/* files.f */
src/cqmr_pkg.sv
src/cqmr_cell.sv
src/circular_queue_with_max_removal.sv
tb/cqmr_checker.sv
tb/tb_top.sv
